[hdl/fevd_pkg.sv]
// Package for the frame energy voice detector: types, constants and threshold table.
`timescale 1ns / 1ps
package fevd_pkg;

	localparam int MAX_FRAME   = 4096;
	localparam int MAX_CHUNK   = 65536;
	localparam int DIV_STEPS   = 47;
	localparam int SQRT_STEPS  = 24;
	localparam int ALU_W       = 48;
	localparam int CE_W        = 47;
	localparam int FE_W        = 42;
	localparam int FP_W        = 12;
	localparam int CNT_W       = 17;
	localparam int FLEN_W      = 13;
	localparam int KN_W        = 37;
	localparam int STEP_W      = 6;
	localparam int RMS_MAX     = 32768;

	typedef enum logic [1:0] {
		REG_GAIN         = 2'd0,
		REG_FRAME_LENGTH = 2'd1,
		REG_DETECT_EN    = 2'd2,
		REG_LEVEL        = 2'd3
	} reg_idx_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_MUL,
		ST_SAT,
		ST_SQ,
		ST_ACC,
		ST_CMP,
		ST_DIV,
		ST_SQRT,
		ST_WRITE
	} state_t;

	typedef struct packed {
		logic signed [15:0] gain;
		logic [FLEN_W-1:0]  frame_length;
		logic               detect_enable;
		logic [1:0]         likelihood_level;
	} cfg_t;

	typedef struct packed {
		logic [CNT_W-1:0]   sample_count;
		logic               voice_seen;
		logic [15:0]        chunk_rms;
		logic               chunk_end;
		logic               voice_flag;
		logic               frame_end;
		logic signed [15:0] clean_sample;
	} res_t;

	// threshold power in Q0.32 for -25, -30, -35, -40 dBFS
	function automatic logic [23:0] thr_k(input logic [1:0] level);
		logic [23:0] k;
		case (level)
			2'd0:    k = 24'd13581879;
			2'd1:    k = 24'd4294967;
			2'd2:    k = 24'd1358188;
			default: k = 24'd429497;
		endcase
		return k;
	endfunction

endpackage

[hdl/fevd_alu.sv]
// Shared subtract and compare unit used by the voice test, divider and square root.
`timescale 1ns / 1ps
module fevd_alu
	import fevd_pkg::*;
(
	input  logic [ALU_W-1:0] a,
	input  logic [ALU_W-1:0] b,
	output logic [ALU_W-1:0] diff,
	output logic             ge
);

	logic [ALU_W:0] sub;

	assign sub  = {1'b0, a} - {1'b0, b};
	assign diff = sub[ALU_W-1:0];
	assign ge   = ~sub[ALU_W];

endmodule

[hdl/fevd_core.sv]
// Sequencer and datapath: gain, energy accumulation, voice test, chunk divide and square root.
`timescale 1ns / 1ps
module fevd_core
	import fevd_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  cfg_t               cfg,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic signed [15:0] in_sample,
	input  logic               in_last,
	input  logic               out_free,
	output logic               res_load,
	output res_t               res
);

	state_t state_q, state_d;

	logic [FE_W-1:0]   fe_q;
	logic [CE_W-1:0]   ce_q;
	logic [FP_W-1:0]   fp_q;
	logic [CNT_W-1:0]  cs_q;
	logic              av_q;

	logic signed [15:0] mic_q;
	logic               last_q;
	logic signed [31:0] prod_q;
	logic signed [15:0] clean_q;
	logic [30:0]        sq_q;
	logic [FLEN_W-1:0]  n_q;
	logic               fend_q;
	logic [KN_W-1:0]    kn_q;
	logic               fvoice_q;
	logic [CE_W-1:0]    work_q;
	logic [CNT_W-1:0]   rem_q;
	logic [CNT_W-1:0]   div_q;
	logic [ALU_W-1:0]   res_q;
	logic [ALU_W-1:0]   bit_q;
	logic [STEP_W-1:0]  step_q;
	logic [CNT_W-1:0]   cnt_q;
	logic               vs_q;

	logic [ALU_W-1:0]   alu_a, alu_b, alu_diff;
	logic               alu_ge;

	logic signed [32:0] rnd, shf;
	logic signed [15:0] sat;
	logic signed [31:0] sqp;
	logic [FLEN_W-1:0]  flen;
	logic [FE_W:0]      fe_sum;
	logic [KN_W-1:0]    kn_mul;
	logic [23:0]        k_w;
	logic [CNT_W:0]     rem_sh;
	logic               fvoice;

	fevd_alu u_alu (
		.a    (alu_a),
		.b    (alu_b),
		.diff (alu_diff),
		.ge   (alu_ge)
	);

	assign rnd    = {prod_q[31], prod_q} + 33'sd2048;
	assign shf    = rnd >>> 12;
	assign sqp    = clean_q * clean_q;
	assign fe_sum = {1'b0, fe_q} + (FE_W+1)'(sq_q);
	assign k_w    = thr_k(cfg.likelihood_level);
	assign kn_mul = KN_W'(k_w) * KN_W'(n_q);
	assign rem_sh = {rem_q, work_q[CE_W-1]};
	assign fvoice = fend_q & cfg.detect_enable & alu_ge;

	always_comb begin
		if (shf > 33'sd32767) begin
			sat = 16'sh7fff;
		end else if (shf < -33'sd32768) begin
			sat = -16'sh8000;
		end else begin
			sat = shf[15:0];
		end
	end

	always_comb begin
		if (cfg.frame_length == '0) begin
			flen = FLEN_W'(1);
		end else if (cfg.frame_length > FLEN_W'(MAX_FRAME)) begin
			flen = FLEN_W'(MAX_FRAME);
		end else begin
			flen = cfg.frame_length;
		end
	end

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE:  if (in_valid) state_d = ST_MUL;
			ST_MUL:   state_d = ST_SAT;
			ST_SAT:   state_d = ST_SQ;
			ST_SQ:    state_d = ST_ACC;
			ST_ACC:   state_d = ST_CMP;
			ST_CMP:   state_d = last_q ? ST_DIV : ST_WRITE;
			ST_DIV:   if (step_q == STEP_W'(1)) state_d = ST_SQRT;
			ST_SQRT:  if (step_q == STEP_W'(1)) state_d = ST_WRITE;
			ST_WRITE: if (out_free) state_d = ST_IDLE;
		endcase
	end

	// outputs and shared unit operands
	always_comb begin
		in_ready = 1'b0;
		res_load = 1'b0;
		alu_a    = '0;
		alu_b    = '0;
		unique case (state_q)
			ST_IDLE:  in_ready = 1'b1;
			ST_CMP: begin
				alu_a = ALU_W'({fe_q, 2'b00});
				alu_b = ALU_W'(kn_q);
			end
			ST_DIV: begin
				alu_a = ALU_W'(rem_sh);
				alu_b = ALU_W'(div_q);
			end
			ST_SQRT: begin
				alu_a = ALU_W'(work_q);
				alu_b = res_q + bit_q;
			end
			ST_WRITE: res_load = out_free;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			fe_q    <= '0;
			ce_q    <= '0;
			fp_q    <= '0;
			cs_q    <= '0;
			av_q    <= 1'b0;
		end else begin
			state_q <= state_d;
			unique case (state_q)
				ST_ACC: begin
					fe_q <= fe_sum[FE_W] ? '1 : fe_sum[FE_W-1:0];
					if (cs_q < CNT_W'(MAX_CHUNK)) begin
						ce_q <= ce_q + CE_W'(sq_q);
						cs_q <= cs_q + CNT_W'(1);
					end
				end
				ST_CMP: begin
					if (last_q) begin
						fe_q <= '0;
						ce_q <= '0;
						fp_q <= '0;
						cs_q <= '0;
						av_q <= 1'b0;
					end else begin
						if (fend_q) begin
							fe_q <= '0;
							fp_q <= '0;
						end else begin
							fp_q <= n_q[FP_W-1:0];
						end
						if (fvoice) av_q <= 1'b1;
					end
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: begin
				mic_q  <= in_sample;
				last_q <= in_last;
			end
			ST_MUL: prod_q <= mic_q * cfg.gain;
			ST_SAT: begin
				clean_q <= sat;
				n_q     <= FLEN_W'(fp_q) + FLEN_W'(1);
			end
			ST_SQ: begin
				sq_q   <= sqp[30:0];
				fend_q <= last_q | (n_q >= flen);
			end
			ST_ACC: kn_q <= kn_mul;
			ST_CMP: begin
				fvoice_q <= fvoice;
				vs_q     <= last_q & (av_q | fvoice);
				cnt_q    <= last_q ? cs_q : '0;
				div_q    <= cs_q;
				work_q   <= ce_q;
				rem_q    <= '0;
				step_q   <= STEP_W'(DIV_STEPS);
			end
			ST_DIV: begin
				rem_q  <= alu_ge ? alu_diff[CNT_W-1:0] : rem_sh[CNT_W-1:0];
				work_q <= {work_q[CE_W-2:0], alu_ge};
				if (step_q == STEP_W'(1)) begin
					step_q <= STEP_W'(SQRT_STEPS);
					res_q  <= '0;
					bit_q  <= ALU_W'(1) << (2 * (SQRT_STEPS - 1));
				end else begin
					step_q <= step_q - STEP_W'(1);
				end
			end
			ST_SQRT: begin
				if (alu_ge) begin
					work_q <= alu_diff[CE_W-1:0];
					res_q  <= (res_q >> 1) + bit_q;
				end else begin
					res_q <= res_q >> 1;
				end
				bit_q  <= bit_q >> 2;
				step_q <= step_q - STEP_W'(1);
			end
			default: ;
		endcase
	end

	always_comb begin
		res.clean_sample = clean_q;
		res.frame_end    = fend_q;
		res.voice_flag   = fvoice_q;
		res.chunk_end    = last_q;
		res.voice_seen   = vs_q;
		res.sample_count = cnt_q;
		if (!last_q) begin
			res.chunk_rms = '0;
		end else if (res_q > ALU_W'(RMS_MAX)) begin
			res.chunk_rms = 16'(RMS_MAX);
		end else begin
			res.chunk_rms = res_q[15:0];
		end
	end

endmodule

[hdl/frame_energy_voice_detector.sv]
// Top level of the frame energy voice detector: register file, core and output register.
//
// Input stream s_*: one microphone sample per request, s_tdata[15:0] = mic_sample
// (Q1.15), s_tlast = last sample of the chunk. Output stream m_*: one result per
// input sample. m_tuser = frame_end, m_tlast = chunk_end, m_tdata carries clean
// sample, frame voice flag and, on the chunk's last result, rms, voice flag and count.
// Configuration: cfg_we with cfg_index / cfg_data writes gain, frame length, detect
// enable and likelihood level; write only while the block is idle.
// Timing: a sample is taken when s_tready is high, then the sequencer runs
// multiply, saturate, square, accumulate and compare steps in turn, then a write
// step loads the output register; s_tready is high only while idle, so the next
// sample is taken after the write. A chunk's last sample adds 47 divide steps and
// 24 square root steps on the shared subtractor before the write.
// Reset clears all accumulators and loads the register defaults (unity gain,
// 480 sample frames, detection on, -30 dBFS). If the receiver stalls, the result
// waits in the output register while the next sample is processed; the core then
// holds in its write step until the register frees.
`timescale 1ns / 1ps
module frame_energy_voice_detector
	import fevd_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [15:0] cfg_data,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [15:0] s_tdata,  // [15:0] mic_sample
	input  logic        s_tlast,
	output logic        m_tvalid,
	input  logic        m_tready,
	// [15:0] clean_sample, [16] voice_flag, [32:17] chunk_rms, [33] voice_seen,
	// [50:34] sample_count, [55:51] zero
	output logic [55:0] m_tdata,
	output logic        m_tuser,  // [0] frame_end
	output logic        m_tlast
);

	cfg_t cfg_q;
	res_t res, out_q;
	logic ovalid_q;
	logic out_free, res_load;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.gain             <= 16'sd4096;
			cfg_q.frame_length     <= FLEN_W'(480);
			cfg_q.detect_enable    <= 1'b1;
			cfg_q.likelihood_level <= 2'd1;
		end else if (cfg_we) begin
			unique case (reg_idx_t'(cfg_index))
				REG_GAIN:         cfg_q.gain             <= cfg_data;
				REG_FRAME_LENGTH: cfg_q.frame_length     <= cfg_data[FLEN_W-1:0];
				REG_DETECT_EN:    cfg_q.detect_enable    <= cfg_data[0];
				REG_LEVEL:        cfg_q.likelihood_level <= cfg_data[1:0];
			endcase
		end
	end

	fevd_core u_core (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.in_valid  (s_tvalid),
		.in_ready  (s_tready),
		.in_sample (s_tdata),
		.in_last   (s_tlast),
		.out_free  (out_free),
		.res_load  (res_load),
		.res       (res)
	);

	assign out_free = ~ovalid_q | m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ovalid_q <= 1'b0;
		end else if (res_load) begin
			ovalid_q <= 1'b1;
		end else if (m_tready) begin
			ovalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_load) out_q <= res;
	end

	assign m_tvalid = ovalid_q;
	assign m_tuser  = out_q.frame_end;
	assign m_tlast  = out_q.chunk_end;
	assign m_tdata  = {5'b0, out_q.sample_count, out_q.voice_seen, out_q.chunk_rms,
		out_q.voice_flag, out_q.clean_sample};

	a_busy_after_req: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("sample taken while core busy");

	a_voice_needs_end: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> !(m_tdata[16] && !m_tuser))
		else $error("frame voice without frame end");

	a_chunk_fields_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tlast |-> m_tdata[50:17] == 34'd0)
		else $error("chunk fields set outside chunk end");

	a_chunk_closes_frame: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tlast |-> m_tuser && m_tdata[50:34] != 17'd0)
		else $error("chunk end without frame end or count");

endmodule

[tb/frame_energy_voice_detector_tb.sv]
// Self-checking testbench for frame_energy_voice_detector: gain, frame voice flags and chunk RMS.
`timescale 1ns / 1ps
module frame_energy_voice_detector_tb;
	import fevd_pkg::*;

	localparam int          CYCLE_LIMIT = 3000000;
	localparam logic [63:0] FRAME_E_MAX = (64'd1 << 42) - 64'd1;
	localparam logic [63:0] VOICE_K [4] = '{64'd13581879, 64'd4294967, 64'd1358188, 64'd429497};

	typedef struct {
		logic [15:0] mic;
		logic        last;
	} mic_item_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        cfg_we = 1'b0;
	logic [1:0]  cfg_index = REG_GAIN;
	logic [15:0] cfg_data = '0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [15:0] s_tdata = '0;
	logic        s_tlast = 1'b0;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [55:0] m_tdata;
	logic        m_tuser;
	logic        m_tlast;

	frame_energy_voice_detector DUT (
		.clk(clk), .arst_n(arst_n),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tlast(s_tlast),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
		.m_tuser(m_tuser), .m_tlast(m_tlast)
	);

	always #5 clk = ~clk;

	// detector shadow: configuration and accumulators
	logic signed [15:0] cfg_gain = 16'sd4096;
	logic [12:0]        cfg_flen = 13'd480;
	logic               cfg_det = 1'b1;
	logic [1:0]         cfg_lvl = 2'd1;
	logic [63:0]        frame_e = '0;
	logic [63:0]        chunk_e = '0;
	int unsigned        frame_pos = 0;
	int unsigned        chunk_n = 0;
	logic               voice_any = 1'b0;

	mic_item_t   mic_q[$];
	res_t        due_results[$];
	mic_item_t   cur_item;
	int          n_queued = 0;
	int          n_accepted = 0;
	int          n_results = 0;
	int          errors = 0;
	int          cycles = 0;
	int          gap_left = 0;
	int          stall_left = 0;
	int          hold_left = 0;
	int          hold_reqs = 0;
	int          hold_served = 0;
	bit          src_idle_on = 1'b1;
	bit          sink_idle_on = 1'b1;
	int          chunk_left = 0;

	function automatic logic [16:0] floor_sqrt(input logic [63:0] v);
		logic [16:0] r;
		logic [16:0] t;
		r = '0;
		for (int b = 16; b >= 0; b--) begin
			t = r | (17'd1 << b);
			if (64'(t) * 64'(t) <= v)
				r = t;
		end
		return r;
	endfunction

	function automatic res_t detect_step(input logic signed [15:0] mic, input logic last);
		res_t              r;
		longint            scaled;
		longint unsigned   sq;
		int unsigned       flen;
		int unsigned       n;
		logic [63:0]       rms;
		r = '0;
		scaled = (longint'(mic) * longint'(cfg_gain) + 64'sd2048) >>> 12;
		if (scaled > 32767)
			scaled = 32767;
		else if (scaled < -32768)
			scaled = -32768;
		sq = scaled * scaled;
		flen = (cfg_flen == 0) ? 1 : (cfg_flen > MAX_FRAME) ? MAX_FRAME : cfg_flen;
		frame_e = frame_e + sq;
		if (frame_e > FRAME_E_MAX)
			frame_e = FRAME_E_MAX;
		if (chunk_n < MAX_CHUNK) begin
			chunk_e = chunk_e + sq;
			chunk_n++;
		end
		n = frame_pos + 1;
		r.clean_sample = 16'(scaled);
		r.frame_end = last || n >= flen;
		r.chunk_end = last;
		if (r.frame_end) begin
			r.voice_flag = cfg_det && ((frame_e << 2) >= VOICE_K[cfg_lvl] * 64'(n));
			if (r.voice_flag)
				voice_any = 1'b1;
			frame_e = '0;
			frame_pos = 0;
		end else begin
			frame_pos = n;
		end
		if (last) begin
			rms = (chunk_n == 0) ? 64'd0 : 64'(floor_sqrt(chunk_e / chunk_n));
			if (rms > RMS_MAX)
				rms = RMS_MAX;
			r.chunk_rms = rms[15:0];
			r.voice_seen = voice_any;
			r.sample_count = chunk_n[16:0];
			frame_e = '0;
			chunk_e = '0;
			frame_pos = 0;
			chunk_n = 0;
			voice_any = 1'b0;
		end
		return r;
	endfunction

	task automatic flag_mismatch(input string msg);
		$display("mismatch at result %0d: %s", n_results, msg);
		errors++;
	endtask

	task automatic queue_sample(input logic [15:0] mic, input logic last);
		mic_item_t it;
		it.mic = mic;
		it.last = last;
		mic_q.push_back(it);
		n_queued++;
	endtask

	task automatic write_reg(input reg_idx_t idx, input logic [15:0] val);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		case (idx)
			REG_GAIN:         cfg_gain = val;
			REG_FRAME_LENGTH: cfg_flen = val[12:0];
			REG_DETECT_EN:    cfg_det = val[0];
			REG_LEVEL:        cfg_lvl = val[1:0];
		endcase
	endtask

	task automatic set_config(input logic [15:0] gain, input logic [12:0] flen,
			input logic det, input logic [1:0] lvl);
		write_reg(REG_GAIN, gain);
		write_reg(REG_FRAME_LENGTH, 16'(flen));
		write_reg(REG_DETECT_EN, 16'(det));
		write_reg(REG_LEVEL, 16'(lvl));
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	// blocks until every queued request is accepted and every result checked
	task automatic drain();
		while (n_accepted != n_queued || due_results.size() != 0)
			@(posedge clk);
		repeat (100) @(posedge clk);
	endtask

	task automatic queue_random_samples(input int count);
		int          amp;
		logic [15:0] mic;
		logic        last;
		amp = 1000;
		for (int i = 0; i < count; i++) begin
			if (chunk_left == 0) begin
				case ($urandom_range(0, 9))
					0:       chunk_left = 1;
					8, 9:    chunk_left = $urandom_range(60, 300);
					default: chunk_left = $urandom_range(2, 60);
				endcase
			end
			if ($urandom_range(0, 7) == 0) begin
				case ($urandom_range(0, 5))
					0: amp = 40;
					1: amp = 400;
					2: amp = 1000;
					3: amp = 1500;
					4: amp = 5000;
					default: amp = 32767;
				endcase
			end
			mic = 16'($urandom_range(0, 2 * amp) - amp);
			last = (chunk_left == 1);
			if ($urandom_range(0, 15) == 0) begin
				mic = 16'($urandom);
				if ($urandom_range(0, 3) == 0)
					last = 1'b1;
			end
			queue_sample(mic, last);
			chunk_left = last ? 0 : chunk_left - 1;
		end
	endtask

	always @(posedge clk) begin
		cycles++;
		if (cycles >= CYCLE_LIMIT) begin
			$display("FAIL");
			$finish;
		end
	end

	// request driver
	always @(posedge clk) begin
		if (!arst_n) begin
			s_tvalid <= 1'b0;
		end else begin
			if (s_tvalid && s_tready) begin
				due_results.push_back(detect_step(cur_item.mic, cur_item.last));
				n_accepted++;
			end
			if (!s_tvalid || s_tready) begin
				if (gap_left != 0) begin
					gap_left--;
					s_tvalid <= 1'b0;
				end else if (mic_q.size() != 0) begin
					if (src_idle_on && $urandom_range(0, 7) == 0) begin
						gap_left = $urandom_range(1, 15) - 1;
						s_tvalid <= 1'b0;
					end else begin
						cur_item = mic_q.pop_front();
						s_tvalid <= 1'b1;
						s_tdata <= cur_item.mic;
						s_tlast <= cur_item.last;
					end
				end else begin
					s_tvalid <= 1'b0;
				end
			end
		end
	end

	// result monitor and sink backpressure
	always @(posedge clk) begin
		res_t e;
		if (!arst_n) begin
			m_tready <= 1'b0;
		end else begin
			if (m_tvalid && m_tready) begin
				if (due_results.size() == 0) begin
					flag_mismatch($sformatf("unexpected result, data %h", m_tdata));
				end else begin
					e = due_results.pop_front();
					if (m_tdata[15:0] !== e.clean_sample)
						flag_mismatch($sformatf("clean_sample %h, want %h",
							m_tdata[15:0], e.clean_sample));
					if (m_tuser !== e.frame_end)
						flag_mismatch($sformatf("frame_end %b, want %b", m_tuser, e.frame_end));
					if (m_tdata[16] !== e.voice_flag)
						flag_mismatch($sformatf("voice_flag %b, want %b",
							m_tdata[16], e.voice_flag));
					if (m_tlast !== e.chunk_end)
						flag_mismatch($sformatf("chunk_end %b, want %b", m_tlast, e.chunk_end));
					if (m_tdata[32:17] !== e.chunk_rms)
						flag_mismatch($sformatf("chunk_rms %0d, want %0d",
							m_tdata[32:17], e.chunk_rms));
					if (m_tdata[33] !== e.voice_seen)
						flag_mismatch($sformatf("voice_seen %b, want %b",
							m_tdata[33], e.voice_seen));
					if (m_tdata[50:34] !== e.sample_count)
						flag_mismatch($sformatf("sample_count %0d, want %0d",
							m_tdata[50:34], e.sample_count));
				end
				n_results++;
			end
			if (hold_left != 0) begin
				hold_left--;
				m_tready <= 1'b0;
			end else if (hold_reqs != hold_served) begin
				hold_served++;
				hold_left = 399;
				m_tready <= 1'b0;
			end else if (stall_left != 0) begin
				stall_left--;
				m_tready <= 1'b0;
			end else if (sink_idle_on && $urandom_range(0, 7) == 0) begin
				stall_left = $urandom_range(1, 15) - 1;
				m_tready <= 1'b0;
			end else begin
				m_tready <= 1'b1;
			end
		end
	end

	initial begin
		logic [15:0] gain;
		logic [12:0] flen;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;

		// reset configuration: full scale, single and multi sample chunks, silence
		queue_sample(16'h8000, 1'b1);
		queue_sample(16'h7FFF, 1'b0);
		queue_sample(16'h0000, 1'b0);
		queue_sample(16'h0001, 1'b0);
		queue_sample(16'hFFFF, 1'b0);
		queue_sample(16'h4000, 1'b0);
		queue_sample(16'hC000, 1'b1);
		queue_sample(16'h0000, 1'b1);
		queue_sample(16'hFFFF, 1'b1);
		drain();

		// max gain saturates both ways; zero frame length closes every sample
		set_config(16'h7FFF, 13'd0, 1'b1, 2'd0);
		queue_sample(16'h8000, 1'b0);
		queue_sample(16'h7FFF, 1'b0);
		queue_sample(16'h0001, 1'b0);
		queue_sample(16'hFFFF, 1'b0);
		queue_sample(16'h0004, 1'b0);
		queue_sample(16'h0000, 1'b1);
		drain();

		// min gain, detection off, chunk ends inside a frame
		set_config(16'h8000, 13'd3, 1'b0, 2'd3);
		queue_sample(16'h7FFF, 1'b0);
		queue_sample(16'h8000, 1'b0);
		queue_sample(16'h0064, 1'b0);
		queue_sample(16'hFF9C, 1'b0);
		queue_sample(16'h0007, 1'b1);
		drain();

		set_config(16'd4096, 13'd4096, 1'b1, 2'd2);
		queue_sample(16'd1000, 1'b0);
		queue_sample(16'd1000, 1'b1);
		drain();

		for (int p = 0; p < 12; p++) begin
			case ($urandom_range(0, 9))
				6:       gain = 16'h7FFF;
				7:       gain = 16'h8000;
				8:       gain = 16'($urandom);
				9:       gain = 16'(-$urandom_range(1, 8192));
				default: gain = 16'($urandom_range(2048, 12288));
			endcase
			case ($urandom_range(0, 9))
				6:       flen = 13'd480;
				7:       flen = 13'd0;
				8:       flen = 13'($urandom_range(100, 300));
				9:       flen = 13'($urandom_range(4096, 8191));
				default: flen = 13'($urandom_range(1, 40));
			endcase
			src_idle_on = (p < 9);
			sink_idle_on = (p < 9);
			set_config(gain, flen, $urandom_range(0, 5) != 0, 2'($urandom_range(0, 3)));
			queue_random_samples(160);
			if (p == 3)
				hold_reqs++;
			drain();
		end

		if (errors == 0 && due_results.size() == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule

[files.f]
hdl/fevd_pkg.sv
hdl/fevd_alu.sv
hdl/fevd_core.sv
hdl/frame_energy_voice_detector.sv
tb/frame_energy_voice_detector_tb.sv
